/* design/csh_pkg.sv */
// ----------------------------------------------------------------------------
// Chunk slot directory package
// Shared types and constants for the chunk slot hash directory.
// ----------------------------------------------------------------------------
package csh_pkg;

    localparam logic [31:0] HASH_MUL_X = 32'd73856093;
    localparam logic [31:0] HASH_MUL_Y = 32'd19349663;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;
    localparam int SLOT_W     = 5;

    // Request kinds; the first three match the action field codes.
    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_LOAD    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // Classified request handed from the front end to the back end.
    // Coordinates are already wrapped and sign-extended to 32 bits.
    typedef struct packed {
        op_t                op;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [SLOT_W-1:0]  rel;
    } cmd_t;

endpackage

/* design/chunk_slot_hash_directory_core.sv */
// ----------------------------------------------------------------------------
// Chunk slot hash directory
// Maps signed chunk coordinates to slots of a fixed pool through a
// linear-probing hash table, with load, eviction and release.
// ----------------------------------------------------------------------------
// After reset the block clears the bucket table and accepts no request
// until that pass ends. BUCKET_COUNT must be a power of two, as the hash is
// masked to it. Requests are then carried out one at a time, while up to two
// more wait in the front-end queue. A lookup passes through a start state,
// the hash (registered products, then the mask), a bucket memory read for
// each bucket probed, a slot coordinate read for each occupied one, and a
// state that hands over the result. A load that misses adds a pool scan
// that reads each slot up to the free slot it stops at and measures the
// distance of every used slot before it; when the pool is full it then
// reads the victim's coordinates, hashes them and probes buckets to remove
// it. Either way it finally writes the slot and probes buckets to insert.
// A release has a start state, a coordinate read, the hash and a probe of
// the buckets. A waiting result holds the back end until it is taken.
module chunk_slot_hash_directory_core #(
    parameter int SLOT_COUNT   = 32,
    parameter int BUCKET_COUNT = 128,
    parameter int COORD_BITS   = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // chunk_x, chunk_y, release_slot, player_chunk_x, player_chunk_y, zero pad
    input  logic [csh_pkg::IN_DATA_W-1:0]      s_tdata,
    // action
    input  logic [csh_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit, slot_index, evicted, zero pad
    output logic [csh_pkg::OUT_DATA_W-1:0]     m_tdata,
    // slot_valid_out
    output logic                               m_tuser
);

    logic                       cmd_valid;
    csh_pkg::cmd_t              cmd;
    logic                       cmd_pop;
    logic                       accept_en;
    logic                       out_hit;
    logic [csh_pkg::SLOT_W-1:0] out_slot;
    logic                       out_evicted;
    logic                       out_slot_valid;

    csh_front #(
        .SLOT_COUNT (SLOT_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .accept_en (accept_en),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    csh_back #(
        .SLOT_COUNT   (SLOT_COUNT),
        .BUCKET_COUNT (BUCKET_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .accept_en      (accept_en),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_hit        (out_hit),
        .out_slot       (out_slot),
        .out_evicted    (out_evicted),
        .out_slot_valid (out_slot_valid)
    );

    assign m_tdata = {1'b0, out_evicted, out_slot, out_hit};
    assign m_tuser = out_slot_valid;

endmodule

/* design/csh_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module csh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

/* design/csh_hash.sv */
// ----------------------------------------------------------------------------
// Bucket hash unit
// Multiplies both coordinates by their constants, XORs the products into a
// register and masks the word to the bucket count, a power of two.
// ----------------------------------------------------------------------------
module csh_hash #(
    parameter int BUCKET_COUNT = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [31:0]              hx,
    input  logic signed [31:0]              hy,
    output logic                            done,
    output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

    localparam int BIDX = $clog2(BUCKET_COUNT);

    logic [31:0] prod_x;
    logic [31:0] prod_y;
    logic [31:0] p_reg;
    logic        done_reg;

    assign prod_x = hx * csh_pkg::HASH_MUL_X;
    assign prod_y = hy * csh_pkg::HASH_MUL_Y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= prod_x ^ prod_y;
        end
    end

    assign done   = done_reg;
    assign bucket = p_reg[BIDX-1:0];

endmodule

/* design/csh_front.sv */
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, wraps the coordinates, classifies the action and
// holds up to two requests for the back end.
// ----------------------------------------------------------------------------
module csh_front #(
    parameter int SLOT_COUNT = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // chunk_x, chunk_y, release_slot, player_chunk_x, player_chunk_y
    input  logic [csh_pkg::IN_DATA_W-1:0]    s_tdata,
    // action
    input  logic [csh_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                             accept_en,
    output logic                             cmd_valid,
    output csh_pkg::cmd_t                    cmd,
    input  logic                             cmd_pop
);

    localparam int SH = 32 - COORD_BITS;

    csh_pkg::cmd_t q_reg [2];
    csh_pkg::cmd_t in_cmd;
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    function automatic logic signed [31:0] wrap(input logic [15:0] f);
        logic signed [31:0] e;
        begin
            e    = 32'(signed'(f));
            wrap = (e <<< SH) >>> SH;
        end
    endfunction

    always_comb
    begin
        in_cmd.op  = csh_pkg::op_t'(s_tuser);
        in_cmd.cx  = wrap(s_tdata[15:0]);
        in_cmd.cy  = wrap(s_tdata[31:16]);
        in_cmd.rel = s_tdata[36:32];
        in_cmd.px  = wrap(s_tdata[52:37]);
        in_cmd.py  = wrap(s_tdata[68:53]);
        // A release of a slot beyond the pool does nothing.
        if (in_cmd.op == csh_pkg::OP_RELEASE && 32'(in_cmd.rel) >= 32'(SLOT_COUNT))
        begin
            in_cmd.op = csh_pkg::OP_NOP;
        end
    end

    assign s_tready  = accept_en && (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign pop       = cmd_pop && cmd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* design/csh_back.sv */
// ----------------------------------------------------------------------------
// Directory back end
// Sequencer that hashes, probes the bucket table, scans the slot pool for a
// free or victim slot, and updates slots and buckets.
// ----------------------------------------------------------------------------
module csh_back #(
    parameter int SLOT_COUNT   = 32,
    parameter int BUCKET_COUNT = 128,
    parameter int COORD_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic                       cmd_valid,
    input  csh_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    output logic                       accept_en,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic                       out_hit,
    output logic [csh_pkg::SLOT_W-1:0] out_slot,
    output logic                       out_evicted,
    output logic                       out_slot_valid
);

    localparam int SIDX = $clog2(SLOT_COUNT);
    localparam int BIDX = $clog2(BUCKET_COUNT);
    localparam int CW   = COORD_BITS;
    localparam int DW   = COORD_BITS + 1;

    typedef enum logic [13:0] {
        ST_CLEAR = 14'b00000000000001,
        ST_IDLE  = 14'b00000000000010,
        ST_CRD   = 14'b00000000000100,
        ST_CLD   = 14'b00000000001000,
        ST_HASH  = 14'b00000000010000,
        ST_BRD   = 14'b00000000100000,
        ST_BCHK  = 14'b00000001000000,
        ST_FRD   = 14'b00000010000000,
        ST_CMP   = 14'b00000100000000,
        ST_SRD   = 14'b00001000000000,
        ST_SCHK  = 14'b00010000000000,
        ST_SDST  = 14'b00100000000000,
        ST_WRITE = 14'b01000000000000,
        ST_DONE  = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_FIND   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_CAND,
        EV_FOUND,
        EV_MISS,
        EV_INS,
        EV_REM,
        EV_REMNO,
        EV_ADV
    } ev_t;

    state_t             state_reg;
    mode_t              mode_reg;
    ev_t                ev;
    csh_pkg::cmd_t      cmd_reg;
    logic               en_reg;
    logic [SLOT_COUNT-1:0] slot_used_reg;
    logic [SIDX-1:0]    slot_reg;
    logic [SIDX-1:0]    c_addr_reg;
    logic [SIDX-1:0]    i_reg;
    logic [SIDX-1:0]    best_reg;
    logic [BIDX-1:0]    b_reg;
    logic [BIDX-1:0]    b_inc;
    logic [BIDX-1:0]    cnt_reg;
    logic [BIDX-1:0]    hlook_reg;
    logic [DW:0]        max_reg;
    logic [DW-1:0]      ax_reg;
    logic [DW-1:0]      ay_reg;
    logic               evict_reg;
    logic               hs_reg;
    logic signed [31:0] hx_reg;
    logic signed [31:0] hy_reg;
    logic               res_hit_reg;
    logic               res_ev_reg;
    logic               res_valid_reg;
    logic               m_valid_reg;
    logic               o_hit_reg;
    logic [csh_pkg::SLOT_W-1:0] o_slot_reg;
    logic               o_ev_reg;
    logic               o_valid_reg;

    logic               h_done;
    logic [BIDX-1:0]    h_bucket;

    logic               bk_we;
    logic [SIDX:0]      bk_wdata;
    logic [SIDX:0]      bk_rdata;
    logic               occ;
    logic [SIDX-1:0]    bs;
    logic               bs_ok;
    logic               step_fail;

    logic               co_we;
    logic [2*CW-1:0]    co_wdata;
    logic [2*CW-1:0]    co_rdata;
    logic [CW-1:0]      rx;
    logic [CW-1:0]      ry;
    logic               match;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW:0]        man_dist;
    logic               upd;
    logic [SIDX-1:0]    new_best;
    logic [SIDX-1:0]    victim;

    csh_hash #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hs_reg),
        .hx     (hx_reg),
        .hy     (hy_reg),
        .done   (h_done),
        .bucket (h_bucket)
    );

    // Bucket entry: occupied flag above the slot number.
    csh_ram #(
        .WIDTH (SIDX + 1),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (bk_we),
        .waddr (b_reg),
        .wdata (bk_wdata),
        .raddr (b_reg),
        .rdata (bk_rdata)
    );

    // Slot coordinates: row above column.
    csh_ram #(
        .WIDTH (2 * CW),
        .DEPTH (SLOT_COUNT)
    ) u_coord_ram (
        .clk   (clk),
        .we    (co_we),
        .waddr (slot_reg),
        .wdata (co_wdata),
        .raddr (c_addr_reg),
        .rdata (co_rdata)
    );

    assign occ       = bk_rdata[SIDX];
    assign bs        = bk_rdata[SIDX-1:0];
    assign bs_ok     = (32'(bs) < 32'(SLOT_COUNT));
    assign step_fail = (cnt_reg == BIDX'(BUCKET_COUNT - 1));
    assign b_inc     = (b_reg == BIDX'(BUCKET_COUNT - 1)) ? '0 : b_reg + 1'b1;

    assign rx    = co_rdata[CW-1:0];
    assign ry    = co_rdata[2*CW-1:CW];
    assign match = slot_used_reg[c_addr_reg] && (rx == cmd_reg.cx[CW-1:0])
                   && (ry == cmd_reg.cy[CW-1:0]);

    assign co_we    = (state_reg == ST_WRITE);
    assign co_wdata = {cmd_reg.cy[CW-1:0], cmd_reg.cx[CW-1:0]};

    assign dx = DW'(signed'(rx)) - DW'(signed'(cmd_reg.px[CW-1:0]));
    assign dy = DW'(signed'(ry)) - DW'(signed'(cmd_reg.py[CW-1:0]));

    assign man_dist = (DW+1)'(ax_reg) + (DW+1)'(ay_reg);
    assign upd      = (i_reg == '0) || (man_dist > max_reg);
    assign new_best = upd ? i_reg : best_reg;
    assign victim   = en_reg ? new_best : '0;

    always_comb
    begin
        bk_we    = 1'b0;
        bk_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            bk_we = 1'b1;
        end
        else if (state_reg == ST_BCHK)
        begin
            if (mode_reg == MODE_INSERT && !occ)
            begin
                bk_we    = 1'b1;
                bk_wdata = {1'b1, slot_reg};
            end
            else if (mode_reg == MODE_REMOVE && occ && bs == slot_reg)
            begin
                bk_we = 1'b1;
            end
        end
    end

    // Outcome of one probe step.
    always_comb
    begin
        ev = EV_NONE;
        if (state_reg == ST_BCHK)
        begin
            if (mode_reg == MODE_FIND && occ && bs_ok)
            begin
                ev = EV_CAND;
            end
            else if (mode_reg == MODE_FIND && !occ)
            begin
                ev = EV_MISS;
            end
            else if (mode_reg == MODE_INSERT && !occ)
            begin
                ev = EV_INS;
            end
            else if (mode_reg == MODE_REMOVE && occ && bs == slot_reg)
            begin
                ev = EV_REM;
            end
            else if (step_fail)
            begin
                unique case (mode_reg)
                    MODE_FIND:   ev = EV_MISS;
                    MODE_INSERT: ev = EV_INS;
                    MODE_REMOVE: ev = EV_REMNO;
                    default:     ev = EV_NONE;
                endcase
            end
            else
            begin
                ev = EV_ADV;
            end
        end
        else if (state_reg == ST_CMP)
        begin
            if (match)
            begin
                ev = EV_FOUND;
            end
            else if (step_fail)
            begin
                ev = EV_MISS;
            end
            else
            begin
                ev = EV_ADV;
            end
        end
    end

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign accept_en = (state_reg != ST_CLEAR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            b_reg         <= '0;
            slot_used_reg <= '0;
            en_reg        <= 1'b0;
            hs_reg        <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            hs_reg <= 1'b0;
            if (cfg_we)
            begin
                en_reg <= cfg_wdata;
            end
            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    b_reg <= b_inc;
                    if (b_reg == BIDX'(BUCKET_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg       <= cmd;
                        evict_reg     <= 1'b0;
                        res_hit_reg   <= 1'b0;
                        res_ev_reg    <= 1'b0;
                        res_valid_reg <= 1'b0;
                        slot_reg      <= '0;
                        unique case (cmd.op) inside
                            csh_pkg::OP_LOOKUP, csh_pkg::OP_LOAD:
                            begin
                                hx_reg    <= cmd.cx;
                                hy_reg    <= cmd.cy;
                                hs_reg    <= 1'b1;
                                mode_reg  <= MODE_FIND;
                                state_reg <= ST_HASH;
                            end
                            csh_pkg::OP_RELEASE:
                            begin
                                slot_reg   <= SIDX'(cmd.rel);
                                c_addr_reg <= SIDX'(cmd.rel);
                                mode_reg   <= MODE_REMOVE;
                                state_reg  <= ST_CRD;
                            end
                            default:
                            begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_CRD:
                begin
                    state_reg <= ST_CLD;
                end
                ST_CLD:
                begin
                    hx_reg    <= 32'(signed'(rx));
                    hy_reg    <= 32'(signed'(ry));
                    hs_reg    <= 1'b1;
                    state_reg <= ST_HASH;
                end
                ST_HASH:
                begin
                    if (h_done)
                    begin
                        b_reg   <= h_bucket;
                        cnt_reg <= '0;
                        if (mode_reg == MODE_FIND)
                        begin
                            hlook_reg <= h_bucket;
                        end
                        state_reg <= ST_BRD;
                    end
                end
                ST_BRD:
                begin
                    state_reg <= ST_BCHK;
                end
                ST_FRD:
                begin
                    state_reg <= ST_CMP;
                end
                ST_SRD:
                begin
                    state_reg <= ST_SCHK;
                end
                ST_SCHK:
                begin
                    if (!slot_used_reg[i_reg])
                    begin
                        slot_reg  <= i_reg;
                        state_reg <= ST_WRITE;
                    end
                    else
                    begin
                        ax_reg    <= dx[DW-1] ? DW'(-dx) : DW'(dx);
                        ay_reg    <= dy[DW-1] ? DW'(-dy) : DW'(dy);
                        state_reg <= ST_SDST;
                    end
                end
                ST_SDST:
                begin
                    if (upd)
                    begin
                        max_reg  <= man_dist;
                        best_reg <= i_reg;
                    end
                    if (i_reg == SIDX'(SLOT_COUNT - 1))
                    begin
                        // Pool is full: unhash the victim before reuse.
                        slot_reg   <= victim;
                        c_addr_reg <= victim;
                        evict_reg  <= 1'b1;
                        mode_reg   <= MODE_REMOVE;
                        state_reg  <= ST_CRD;
                    end
                    else
                    begin
                        i_reg      <= i_reg + 1'b1;
                        c_addr_reg <= i_reg + 1'b1;
                        state_reg  <= ST_SRD;
                    end
                end
                ST_WRITE:
                begin
                    slot_used_reg[slot_reg] <= 1'b1;
                    b_reg     <= hlook_reg;
                    cnt_reg   <= '0;
                    mode_reg  <= MODE_INSERT;
                    state_reg <= ST_BRD;
                end
                ST_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        o_hit_reg   <= res_hit_reg;
                        o_slot_reg  <= res_valid_reg ? csh_pkg::SLOT_W'(slot_reg) : '0;
                        o_ev_reg    <= res_ev_reg;
                        o_valid_reg <= res_valid_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                end
            endcase

            case (ev) inside
                EV_CAND:
                begin
                    c_addr_reg <= bs;
                    state_reg  <= ST_FRD;
                end
                EV_FOUND:
                begin
                    slot_reg      <= c_addr_reg;
                    res_hit_reg   <= 1'b1;
                    res_valid_reg <= 1'b1;
                    state_reg     <= ST_DONE;
                end
                EV_MISS:
                begin
                    if (cmd_reg.op == csh_pkg::OP_LOAD)
                    begin
                        i_reg      <= '0;
                        c_addr_reg <= '0;
                        state_reg  <= ST_SRD;
                    end
                    else
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                EV_INS:
                begin
                    res_valid_reg <= 1'b1;
                    res_ev_reg    <= evict_reg;
                    state_reg     <= ST_DONE;
                end
                EV_REM, EV_REMNO:
                begin
                    if (cmd_reg.op == csh_pkg::OP_RELEASE)
                    begin
                        slot_used_reg[slot_reg] <= 1'b0;
                        res_hit_reg   <= (ev == EV_REM);
                        res_valid_reg <= 1'b1;
                        state_reg     <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_WRITE;
                    end
                end
                EV_ADV:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    b_reg     <= b_inc;
                    state_reg <= ST_BRD;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign m_tvalid       = m_valid_reg;
    assign out_hit        = o_hit_reg;
    assign out_slot       = o_slot_reg;
    assign out_evicted    = o_ev_reg;
    assign out_slot_valid = o_valid_reg;

endmodule
